// ===== rtl/mkde_pkg.sv =====
package mkde_pkg;

    localparam int MAX_KEYS = 16;
    localparam int FIFO_DEPTH = 2;

    localparam logic [15:0] ALL_RELEASED = 16'hFFFF;
    localparam logic [15:0] DEBOUNCE_RESET = 16'd20;

    typedef struct packed {
        logic [15:0] raw_levels;
        logic [15:0] now_ms;
    } scan_t;

    typedef struct packed {
        logic [1:0] key_row;
        logic [1:0] key_col;
        logic       pressed;
        logic       last;
    } key_event_t;

    // One scan's worth of debounced flips: which keys fire, and their new levels.
    typedef struct packed {
        logic [MAX_KEYS-1:0] fire;
        logic [MAX_KEYS-1:0] level;
    } ev_batch_t;

endpackage

// ===== rtl/mkde_fifo.sv =====
module mkde_fifo #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count exceeds depth");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && empty))
        else $error("pop from empty queue");
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full queue");

endmodule

// ===== rtl/mkde_front.sv =====
module mkde_front #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [15:0]         cfg_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  mkde_pkg::scan_t     s_data,
    output logic                push,
    output mkde_pkg::ev_batch_t push_data,
    input  logic                full
);
    import mkde_pkg::*;

    localparam int KEYS = (ROWS * COLS > MAX_KEYS) ? MAX_KEYS : ROWS * COLS;
    localparam logic [15:0] KEY_MASK = 16'((32'd1 << KEYS) - 32'd1);

    logic [15:0] debounce_reg;
    logic [15:0] prev_raw_reg, prev_raw_next;
    logic [15:0] stable_reg, stable_next;
    logic [15:0] ct_reg [KEYS];
    logic [15:0] ct_next [KEYS];

    logic        accept;
    logic [15:0] raw;
    logic [15:0] changed;
    logic [15:0] held [KEYS];
    logic [15:0] fire;

    assign cfg_ready = 1'b1;
    assign s_ready   = !full;
    assign accept    = s_valid && s_ready;

    // Bits above the key count read as released so they never fire.
    assign raw     = (s_data.raw_levels & KEY_MASK) | ~KEY_MASK;
    assign changed = prev_raw_reg ^ raw;

    always_comb begin
        fire = '0;
        for (int i = 0; i < KEYS; i++) begin
            // A key that changed on this scan restarts its hold time at zero.
            held[i] = changed[i] ? 16'd0 : s_data.now_ms - ct_reg[i];
            fire[i] = (raw[i] != stable_reg[i]) && (held[i] >= debounce_reg);
        end
    end

    always_comb begin
        prev_raw_next = prev_raw_reg;
        stable_next   = stable_reg;
        for (int i = 0; i < KEYS; i++) begin
            ct_next[i] = ct_reg[i];
        end
        if (accept) begin
            prev_raw_next = raw;
            stable_next   = stable_reg ^ fire;
            for (int i = 0; i < KEYS; i++) begin
                if (changed[i]) begin
                    ct_next[i] = s_data.now_ms;
                end
            end
        end
    end

    assign push            = accept && (fire != '0);
    assign push_data.fire  = fire;
    assign push_data.level = raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg <= DEBOUNCE_RESET;
            prev_raw_reg <= ALL_RELEASED;
            stable_reg   <= ALL_RELEASED;
            for (int i = 0; i < KEYS; i++) begin
                ct_reg[i] <= '0;
            end
        end else begin
            if (cfg_valid && cfg_ready) begin
                debounce_reg <= cfg_data;
            end
            prev_raw_reg <= prev_raw_next;
            stable_reg   <= stable_next;
            for (int i = 0; i < KEYS; i++) begin
                ct_reg[i] <= ct_next[i];
            end
        end
    end

    a_fire_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire & ~KEY_MASK) == '0)
        else $error("event flagged for a position beyond the key count");
    a_unused_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (stable_reg | KEY_MASK) == ALL_RELEASED)
        else $error("unused stable bit left released state");
    a_fire_flips: assert property (@(posedge aclk) disable iff (!aresetn)
        push |=> ((stable_reg ^ $past(stable_reg)) == $past(fire)))
        else $error("stable vector did not flip exactly the fired keys");

endmodule

// ===== rtl/mkde_back.sv =====
module mkde_back #(
    parameter int COLS = 4
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  mkde_pkg::ev_batch_t    pop_data,
    input  logic                   empty,
    output logic                   pop,
    output logic                   m_valid,
    input  logic                   m_ready,
    output mkde_pkg::key_event_t   m_data
);
    import mkde_pkg::*;

    localparam int PW = $clog2(MAX_KEYS);

    logic [MAX_KEYS-1:0] mask_reg, mask_next;
    logic [MAX_KEYS-1:0] level_reg, level_next;
    logic                m_valid_reg, m_valid_next;
    key_event_t          m_data_reg, m_data_next;

    logic [1:0]          row_tab [MAX_KEYS];
    logic [1:0]          col_tab [MAX_KEYS];
    logic [MAX_KEYS-1:0] low;
    logic [MAX_KEYS-1:0] rest;
    logic [MAX_KEYS-1:0] mask_after;
    logic [PW-1:0]       pos;
    logic                adv;
    logic                emit;

    for (genvar g = 0; g < MAX_KEYS; g++) begin : g_tab
        assign row_tab[g] = 2'(g / COLS);
        assign col_tab[g] = 2'(g % COLS);
    end

    assign low  = mask_reg & (~mask_reg + 1'b1);
    assign rest = mask_reg & ~low;

    always_comb begin
        pos = '0;
        for (int i = MAX_KEYS - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                pos = PW'(i);
            end
        end
    end

    // The output register advances when it is empty or its transfer completes.
    assign adv        = !m_valid_reg || m_ready;
    assign emit       = adv && (mask_reg != '0);
    assign mask_after = emit ? rest : mask_reg;
    assign pop        = (mask_after == '0) && !empty;

    always_comb begin
        mask_next    = pop ? pop_data.fire : mask_after;
        level_next   = pop ? pop_data.level : level_reg;
        m_valid_next = adv ? (mask_reg != '0) : m_valid_reg;
        m_data_next  = m_data_reg;
        if (emit) begin
            m_data_next.key_row = row_tab[pos];
            m_data_next.key_col = col_tab[pos];
            m_data_next.pressed = !level_reg[pos];
            m_data_next.last    = (rest == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            mask_reg    <= mask_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        level_reg  <= level_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_more_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.last) |-> (mask_reg != '0))
        else $error("non-final event shown with no events left in the scan");
    a_pop_when_done: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (mask_after == '0))
        else $error("new scan loaded while events of the previous one remain");
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && (mask_reg == '0) && empty) |=> !m_valid_reg)
        else $error("event shown with nothing pending");

endmodule

// ===== rtl/matrix_key_debounce_events.sv =====
// Debounces scans of a ROWS x COLS key matrix (up to 16 keys, key index row*COLS+col,
// raw level 1 = released) and reports each debounced press or release as one event
// carrying row, column, direction and a flag on the final event of its scan. A key
// flips once its raw level differs from the debounced level and has held for at least
// debounce_ms milliseconds (modulo-65536 time; 0 accepts a new level at once); the
// register resets to 20 and may be written through the cfg channel while the block is
// idle. A scan is accepted whenever the two-entry event queue has room, and a scan
// that causes no event produces no output. Events leave the output register one per
// cycle while m_ready is high, in ascending key index, and the emitter picks up the
// next queued scan in the cycle that it issues the final event of the current one.
// When the emitter is free, the first event of a scan passes from the event queue
// through the emitter's mask register into the output register.
module matrix_key_debounce_events #(
    parameter int ROWS = 4,
    parameter int COLS = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [15:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mkde_pkg::scan_t      s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mkde_pkg::key_event_t m_data
);
    import mkde_pkg::*;

    logic      push;
    logic      pop;
    logic      full;
    logic      empty;
    ev_batch_t push_data;
    ev_batch_t pop_data;

    mkde_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    mkde_fifo #(
        .WIDTH ($bits(ev_batch_t)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (empty)
    );

    mkde_back #(
        .COLS (COLS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pop_data (pop_data),
        .empty    (empty),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule
